/* hdl/mau_pkg.sv */
// Shared constants, codes and types of the modular arithmetic unit.
package mau_pkg;

   localparam int FuncWidth    = 3;
   localparam int OperandWidth = 64;
   localparam int ModWidth     = 31;
   localparam int ExpBits      = 64;
   localparam int KWidth       = $clog2(ModWidth + 1);
   localparam int MuWidth      = ModWidth + 2;
   localparam int ExpCntWidth  = $clog2(ExpBits + 1);

   localparam logic [ModWidth-1:0] ModReset = ModWidth'(1000000007);

   localparam logic [FuncWidth-1:0] FUNC_ADD = 3'd0;
   localparam logic [FuncWidth-1:0] FUNC_SUB = 3'd1;
   localparam logic [FuncWidth-1:0] FUNC_MUL = 3'd2;
   localparam logic [FuncWidth-1:0] FUNC_POW = 3'd3;
   localparam logic [FuncWidth-1:0] FUNC_INV = 3'd4;
   localparam logic [FuncWidth-1:0] FUNC_DIV = 3'd5;

   typedef struct packed {
      logic [ModWidth-1:0] m;
      logic [KWidth-1:0]   k;
      logic [MuWidth-1:0]  mu;
   } mau_mod_type;

   typedef struct packed {
      logic                start;
      logic [ModWidth-1:0] u;
      logic [ModWidth-1:0] v;
   } mau_mm_req_type;

   typedef struct packed {
      logic                done;
      logic [ModWidth-1:0] prod;
   } mau_mm_rsp_type;

   typedef struct packed {
      logic                done;
      logic [ModWidth-1:0] a_mod;
      logic [ModWidth-1:0] b_mod;
      logic [MuWidth-1:0]  mu;
   } mau_red_rsp_type;

endpackage

/* hdl/mau_if.sv */
// Valid/ready channels of the modular arithmetic unit: request, response, csr.
interface mau_req_if;
   logic                              valid;
   logic                              ready;
   logic [mau_pkg::FuncWidth-1:0]     func;
   logic [mau_pkg::OperandWidth-1:0]  operand_a;
   logic [mau_pkg::OperandWidth-1:0]  operand_b;

   modport source (output valid, func, operand_a, operand_b, input ready);
   modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface mau_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mau_pkg::ModWidth-1:0]  result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface

interface mau_csr_if;
   logic                          valid;
   logic                          ready;
   logic [mau_pkg::ModWidth-1:0]  modulus;

   modport source (output valid, modulus, input ready);
   modport sink   (input valid, modulus, output ready);
endinterface

/* hdl/mau_reducer.sv */
// Bit-serial remainder unit: operands mod m and the Barrett factor 2^(2k) / m.
module mau_reducer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [mau_pkg::ModWidth-1:0]     modulus,
   input  logic [mau_pkg::KWidth-1:0]       k,
   input  logic [mau_pkg::OperandWidth-1:0] operand_a,
   input  logic [mau_pkg::OperandWidth-1:0] operand_b,
   output mau_pkg::mau_red_rsp_type         rsp
);
   import mau_pkg::*;

   localparam int CntWidth = $clog2(OperandWidth);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CntWidth-1:0]     cnt_ff, cnt_in;
   logic [OperandWidth-1:0] sha_ff, sha_in;
   logic [OperandWidth-1:0] shb_ff, shb_in;
   logic [OperandWidth-1:0] shp_ff, shp_in;
   logic [ModWidth-1:0]     ra_ff, ra_in;
   logic [ModWidth-1:0]     rb_ff, rb_in;
   logic [ModWidth-1:0]     rp_ff, rp_in;
   logic [MuWidth-1:0]      q_ff, q_in;
   logic [ModWidth:0]       step_a, step_b, step_p;

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [ModWidth:0] lane_step(input logic [ModWidth-1:0] r,
                                                   input logic din,
                                                   input logic [ModWidth-1:0] m);
      logic [ModWidth:0] t;
      logic [ModWidth:0] d;
      t = {r, din};
      d = t - {1'b0, m};
      if (t >= {1'b0, m}) begin
         lane_step = {1'b1, d[ModWidth-1:0]};
      end else begin
         lane_step = {1'b0, t[ModWidth-1:0]};
      end
   endfunction

   assign step_a = lane_step(ra_ff, sha_ff[OperandWidth-1], modulus);
   assign step_b = lane_step(rb_ff, shb_ff[OperandWidth-1], modulus);
   assign step_p = lane_step(rp_ff, shp_ff[OperandWidth-1], modulus);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sha_in  = sha_ff;
      shb_in  = shb_ff;
      shp_in  = shp_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      rp_in   = rp_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sha_in  = operand_a;
         shb_in  = operand_b;
         shp_in  = OperandWidth'(1) << {k, 1'b0};
         ra_in   = '0;
         rb_in   = '0;
         rp_in   = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         sha_in = sha_ff << 1;
         shb_in = shb_ff << 1;
         shp_in = shp_ff << 1;
         ra_in  = step_a[ModWidth-1:0];
         rb_in  = step_b[ModWidth-1:0];
         rp_in  = step_p[ModWidth-1:0];
         q_in   = {q_ff[MuWidth-2:0], step_p[ModWidth]};
         cnt_in = cnt_ff + CntWidth'(1);
         if (cnt_ff == CntWidth'(OperandWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      sha_ff <= sha_in;
      shb_ff <= shb_in;
      shp_ff <= shp_in;
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
      rp_ff  <= rp_in;
      q_ff   <= q_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.a_mod = ra_ff;
   assign rsp.b_mod = rb_ff;
   assign rsp.mu    = q_ff;

   a_red_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (ra_ff < modulus) && (rb_ff < modulus))
      else $error("reducer remainder not below modulus");

endmodule

/* hdl/mau_mulmod.sv */
// Shared modular multiplier: one multiplier reused for Barrett product, quotient, remainder.
module mau_mulmod (
   input  logic                     clock,
   input  logic                     reset,
   input  mau_pkg::mau_mm_req_type  mm_req,
   input  mau_pkg::mau_mod_type     mod,
   output mau_pkg::mau_mm_rsp_type  mm_rsp
);
   import mau_pkg::*;

   localparam logic [2:0] MM_IDLE = 3'd0;
   localparam logic [2:0] MM_X    = 3'd1;
   localparam logic [2:0] MM_Q    = 3'd2;
   localparam logic [2:0] MM_R    = 3'd3;
   localparam logic [2:0] MM_FIX  = 3'd4;

   localparam int MulWidth = MuWidth;
   localparam int XWidth   = 2 * ModWidth;
   localparam int RWidth   = ModWidth + 3;

   logic [2:0]            state_ff, state_in;
   logic                  done_ff, done_in;
   logic [ModWidth-1:0]   u_ff, u_in;
   logic [ModWidth-1:0]   v_ff, v_in;
   logic [XWidth-1:0]     x_ff, x_in;
   logic [ModWidth-1:0]   q3_ff, q3_in;
   logic [RWidth-1:0]     r_ff, r_in;
   logic [ModWidth-1:0]   res_ff, res_in;
   logic [MulWidth-1:0]   op_a, op_b;
   logic [2*MulWidth-1:0] prod;
   logic [KWidth-1:0]     km1;
   logic [KWidth:0]       kp1;
   logic [RWidth-1:0]     m1, m2;

   assign km1  = mod.k - KWidth'(1);
   assign kp1  = {1'b0, mod.k} + (KWidth + 1)'(1);
   assign m1   = RWidth'(mod.m);
   assign m2   = RWidth'({mod.m, 1'b0});
   assign prod = op_a * op_b;

   always_comb begin
      unique case (state_ff)
         MM_X: begin
            op_a = MulWidth'(u_ff);
            op_b = MulWidth'(v_ff);
         end
         MM_Q: begin
            op_a = MulWidth'(x_ff >> km1);
            op_b = mod.mu;
         end
         MM_R: begin
            op_a = MulWidth'(q3_ff);
            op_b = MulWidth'(mod.m);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      u_in     = u_ff;
      v_in     = v_ff;
      x_in     = x_ff;
      q3_in    = q3_ff;
      r_in     = r_ff;
      res_in   = res_ff;
      unique case (state_ff)
         MM_IDLE: begin
            if (mm_req.start) begin
               u_in     = mm_req.u;
               v_in     = mm_req.v;
               state_in = MM_X;
            end
         end
         MM_X: begin
            x_in     = prod[XWidth-1:0];
            state_in = MM_Q;
         end
         MM_Q: begin
            q3_in    = ModWidth'(prod >> kp1);
            state_in = MM_R;
         end
         MM_R: begin
            r_in     = x_ff[RWidth-1:0] - prod[RWidth-1:0];
            state_in = MM_FIX;
         end
         MM_FIX: begin
            // remainder below 3m: at most two corrections
            if (r_ff >= m2) begin
               res_in = ModWidth'(r_ff - m2);
            end else if (r_ff >= m1) begin
               res_in = ModWidth'(r_ff - m1);
            end else begin
               res_in = ModWidth'(r_ff);
            end
            done_in  = 1'b1;
            state_in = MM_IDLE;
         end
         default: begin
            state_in = MM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff   <= u_in;
      v_ff   <= v_in;
      x_ff   <= x_in;
      q3_ff  <= q3_in;
      r_ff   <= r_in;
      res_ff <= res_in;
   end

   assign mm_rsp.done = done_ff;
   assign mm_rsp.prod = res_ff;

   a_mm_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (res_ff < mod.m))
      else $error("modular product not below modulus");

   a_mm_start_idle: assert property (@(posedge clock) disable iff (reset)
      mm_req.start |-> (state_ff == MM_IDLE))
      else $error("multiply started while busy");

endmodule

/* hdl/modular_arithmetic_unit.sv */
// Top level of the modular arithmetic unit: csr register, sequencer, response register.
//
//   channel  | dir | handshake          | word
//   req_chan | in  | valid/ready        | func, operand_a, operand_b
//   rsp_chan | out | valid/ready        | result
//   csr_chan | in  | valid/ready (rdy=1) | modulus
//
// Each accepted word runs 64 remainder steps, then the multiplies of its function.
// Modulus below two: result 0 at once; add/sub: no multiply; multiply: one multiply.
// Power: 64 + set exponent bits multiplies.
// Inverse: 31 + set bits of (modulus - 2) multiplies; divide one multiply more.
// Reset is synchronous; modulus resets to 1000000007. The response register lets
// a new word enter while the previous result waits; only the handoff stalls on it.
module modular_arithmetic_unit (
   input logic       clock,
   input logic       reset,
   mau_req_if.sink   req_chan,
   mau_rsp_if.source rsp_chan,
   mau_csr_if.sink   csr_chan
);
   import mau_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RED  = 3'd1;
   localparam logic [2:0] ST_SQ   = 3'd2;
   localparam logic [2:0] ST_MB   = 3'd3;
   localparam logic [2:0] ST_POST = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   localparam int ExpPad = OperandWidth - ExpBits;
   localparam int InvPad = OperandWidth - ModWidth;

   logic [2:0]              state_ff, state_in;
   logic [ModWidth-1:0]     modulus_ff, modulus_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ModWidth-1:0]     rsp_result_ff, rsp_result_in;
   mau_mm_req_type          mm_req_ff, mm_req_in;
   logic [FuncWidth-1:0]    func_ff, func_in;
   logic [OperandWidth-1:0] opb_ff, opb_in;
   logic [KWidth-1:0]       k_ff, k_in;
   logic [ModWidth-1:0]     a_ff, a_in;
   logic [MuWidth-1:0]      mu_ff, mu_in;
   logic [ModWidth-1:0]     base_ff, base_in;
   logic [ModWidth-1:0]     acc_ff, acc_in;
   logic [OperandWidth-1:0] exp_ff, exp_in;
   logic [ExpCntWidth-1:0]  cnt_ff, cnt_in;
   logic [ModWidth-1:0]     res_ff, res_in;

   logic                    accept;
   logic                    mod_ok;
   logic [KWidth-1:0]       k_calc;
   logic                    red_start;
   mau_red_rsp_type         red_rsp;
   mau_mod_type             mod;
   mau_mm_rsp_type          mm_rsp;
   logic [ModWidth:0]       add_sum;
   logic [ModWidth:0]       add_red;
   logic [ModWidth:0]       sub_wrap;

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign csr_chan.ready  = 1'b1;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.result = rsp_result_ff;

   assign accept    = req_chan.valid && req_chan.ready;
   assign mod_ok    = (modulus_ff >= ModWidth'(2));
   assign red_start = accept && mod_ok;

   always_comb begin
      k_calc = '0;
      for (int i = 0; i < ModWidth; i++) begin
         if (modulus_ff[i]) begin
            k_calc = KWidth'(i + 1);
         end
      end
   end

   assign mod.m  = modulus_ff;
   assign mod.k  = k_ff;
   assign mod.mu = mu_ff;

   assign add_sum  = {1'b0, red_rsp.a_mod} + {1'b0, red_rsp.b_mod};
   assign add_red  = add_sum - {1'b0, modulus_ff};
   assign sub_wrap = {1'b0, red_rsp.a_mod} + {1'b0, modulus_ff} - {1'b0, red_rsp.b_mod};

   mau_reducer u_reducer (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .modulus   (modulus_ff),
      .k         (k_calc),
      .operand_a (req_chan.operand_a),
      .operand_b (req_chan.operand_b),
      .rsp       (red_rsp)
   );

   mau_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req_ff),
      .mod    (mod),
      .mm_rsp (mm_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      modulus_in    = modulus_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      mm_req_in     = '{start: 1'b0, u: mm_req_ff.u, v: mm_req_ff.v};
      func_in       = func_ff;
      opb_in        = opb_ff;
      k_in          = k_ff;
      a_in          = a_ff;
      mu_in         = mu_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      exp_in        = exp_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;

      if (csr_chan.valid && csr_chan.ready) begin
         modulus_in = csr_chan.modulus;
      end
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in = req_chan.func;
               opb_in  = req_chan.operand_b;
               k_in    = k_calc;
               if (mod_ok) begin
                  state_in = ST_RED;
               end else begin
                  res_in   = '0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_RED: begin
            if (red_rsp.done) begin
               a_in  = red_rsp.a_mod;
               mu_in = red_rsp.mu;
               case (func_ff) inside
                  FUNC_ADD: begin
                     res_in   = (add_sum >= {1'b0, modulus_ff}) ? add_red[ModWidth-1:0]
                                                                 : add_sum[ModWidth-1:0];
                     state_in = ST_OUT;
                  end
                  FUNC_SUB: begin
                     res_in   = (red_rsp.a_mod >= red_rsp.b_mod)
                                ? (red_rsp.a_mod - red_rsp.b_mod)
                                : sub_wrap[ModWidth-1:0];
                     state_in = ST_OUT;
                  end
                  FUNC_MUL: begin
                     mm_req_in = '{start: 1'b1, u: red_rsp.a_mod, v: red_rsp.b_mod};
                     state_in  = ST_FIN;
                  end
                  FUNC_POW: begin
                     base_in   = red_rsp.a_mod;
                     exp_in    = opb_ff << ExpPad;
                     cnt_in    = ExpCntWidth'(ExpBits);
                     mm_req_in = '{start: 1'b1, u: ModWidth'(1), v: ModWidth'(1)};
                     state_in  = ST_SQ;
                  end
                  FUNC_INV, FUNC_DIV: begin
                     base_in   = (func_ff == FUNC_DIV) ? red_rsp.b_mod : red_rsp.a_mod;
                     exp_in    = {modulus_ff - ModWidth'(2), {InvPad{1'b0}}};
                     cnt_in    = ExpCntWidth'(ModWidth);
                     mm_req_in = '{start: 1'b1, u: ModWidth'(1), v: ModWidth'(1)};
                     state_in  = ST_SQ;
                  end
                  default: begin
                     res_in   = '0;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_SQ: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.prod;
               if (exp_ff[OperandWidth-1]) begin
                  mm_req_in = '{start: 1'b1, u: mm_rsp.prod, v: base_ff};
                  state_in  = ST_MB;
               end else begin
                  exp_in = exp_ff << 1;
                  cnt_in = cnt_ff - ExpCntWidth'(1);
                  if (cnt_ff == ExpCntWidth'(1)) begin
                     state_in = ST_POST;
                  end else begin
                     mm_req_in = '{start: 1'b1, u: mm_rsp.prod, v: mm_rsp.prod};
                  end
               end
            end
         end
         ST_MB: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.prod;
               exp_in = exp_ff << 1;
               cnt_in = cnt_ff - ExpCntWidth'(1);
               if (cnt_ff == ExpCntWidth'(1)) begin
                  state_in = ST_POST;
               end else begin
                  mm_req_in = '{start: 1'b1, u: mm_rsp.prod, v: mm_rsp.prod};
                  state_in  = ST_SQ;
               end
            end
         end
         ST_POST: begin
            if (func_ff == FUNC_DIV) begin
               mm_req_in = '{start: 1'b1, u: a_ff, v: acc_ff};
               state_in  = ST_FIN;
            end else begin
               res_in   = acc_ff;
               state_in = ST_OUT;
            end
         end
         ST_FIN: begin
            if (mm_rsp.done) begin
               res_in   = mm_rsp.prod;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         modulus_ff      <= ModReset;
         rsp_valid_ff    <= 1'b0;
         mm_req_ff.start <= 1'b0;
      end else begin
         state_ff        <= state_in;
         modulus_ff      <= modulus_in;
         rsp_valid_ff    <= rsp_valid_in;
         mm_req_ff.start <= mm_req_in.start;
         mm_req_ff.u     <= mm_req_in.u;
         mm_req_ff.v     <= mm_req_in.v;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
      func_ff       <= func_in;
      opb_ff        <= opb_in;
      k_ff          <= k_in;
      a_ff          <= a_in;
      mu_ff         <= mu_in;
      base_ff       <= base_in;
      acc_ff        <= acc_in;
      exp_ff        <= exp_in;
      cnt_ff        <= cnt_in;
      res_ff        <= res_in;
   end

   a_out_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready)
      |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("result not handed to response register");

   a_mm_done_state: assert property (@(posedge clock) disable iff (reset)
      mm_rsp.done |-> (state_ff == ST_SQ) || (state_ff == ST_MB) || (state_ff == ST_FIN))
      else $error("multiplier finished with no waiting step");

endmodule
